[src/wah_bitmap_and_or_assert.svh]
// ----------------------------------------------------------------------------
// WAH bitmap merge assertion macros
// Shared macros for the concurrent checks of the merge block.
// ----------------------------------------------------------------------------
`ifndef WAH_BITMAP_AND_OR_ASSERT_SVH
`define WAH_BITMAP_AND_OR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WAH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wah check failed");

// The consequent must hold in the cycle after the antecedent.
`define WAH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wah check failed");

`endif

[src/wah_pkg.sv]
// ----------------------------------------------------------------------------
// WAH bitmap merge package
// Constants, controller states and the command/status bundles of the block.
// ----------------------------------------------------------------------------
package wah_pkg;

    localparam int MAX_WORDS_DEF = 16;
    localparam int MAX_OUT       = 64;
    localparam int NOUT_W        = $clog2(MAX_OUT);

    localparam logic [29:0] LEN_MASK = 30'h3fffffff;
    localparam logic [30:0] LIT_ONES = 31'h7fffffff;
    localparam logic [29:0] LIT_BITS = 30'd31;

    localparam logic OP_AND = 1'b0;
    localparam logic OP_OR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_EVAL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic init;
        logic chunk;
        logic apply;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic trig;
        logic loop_ok;
        logic run_nz;
        logic need_flush;
        logic kind_lit;
        logic can_push;
        logic at_limit;
        logic fin_ok;
    } t_sts;

endpackage

[src/wah_ctrl.sv]
// ----------------------------------------------------------------------------
// WAH merge controller
// Sequences loading, the merge walk, run flushing and the final word.
// ----------------------------------------------------------------------------
module wah_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wah_pkg::t_sts i_sts,
    output wah_pkg::t_cmd o_cmd
);

    wah_pkg::t_state r_state;
    wah_pkg::t_state n_state;

    logic do_chunk;
    logic do_apply;
    logic emits;
    logic go;

    // A step either flushes one chunk of the running fill or applies itself.
    always_comb begin
        do_chunk = (!i_sts.loop_ok && i_sts.run_nz) || (i_sts.loop_ok && i_sts.need_flush);
        do_apply = i_sts.loop_ok && !i_sts.need_flush;
        emits    = do_chunk || (do_apply && i_sts.kind_lit);
        go       = !emits || i_sts.can_push;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wah_pkg::ST_IDLE: begin
                if (i_in_valid && i_sts.trig) begin
                    n_state = wah_pkg::ST_PREP;
                end
            end
            wah_pkg::ST_PREP: begin
                n_state = wah_pkg::ST_EVAL;
            end
            wah_pkg::ST_EVAL: begin
                if (!i_sts.loop_ok && !i_sts.run_nz) begin
                    n_state = wah_pkg::ST_FINISH;
                end else if (emits && go && i_sts.at_limit) begin
                    n_state = wah_pkg::ST_FINISH;
                end
            end
            wah_pkg::ST_FINISH: begin
                if (i_sts.fin_ok) begin
                    n_state = wah_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wah_pkg::ST_IDLE;
            end
        endcase
    end

    // No request is taken while reset is held.
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            wah_pkg::ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            wah_pkg::ST_PREP: begin
                o_cmd.init = 1'b1;
            end
            wah_pkg::ST_EVAL: begin
                o_cmd.chunk = do_chunk && go;
                o_cmd.apply = do_apply && go;
            end
            wah_pkg::ST_FINISH: begin
                o_cmd.finish = i_sts.fin_ok;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wah_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/wah_dp.sv]
// ----------------------------------------------------------------------------
// WAH merge datapath
// Operand stores, walk indexes, running fill counter and the output stages.
// ----------------------------------------------------------------------------
`include "wah_bitmap_and_or_assert.svh"

module wah_dp #(
    parameter int MAX_WORDS = wah_pkg::MAX_WORDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_mode,
    input  logic          i_operand_select,
    input  logic [31:0]   i_comp_word,
    input  logic          i_last_word,
    input  wah_pkg::t_cmd i_cmd,
    output wah_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [31:0]   o_result_word,
    output logic          o_last_result
);

    localparam int CW    = $clog2(MAX_WORDS + 1);
    localparam int IW    = $clog2(MAX_WORDS);
    localparam int RUN_W = 30 + $clog2(2 * MAX_WORDS + 1);

    logic [31:0] r_store1 [MAX_WORDS];
    logic [31:0] r_store2 [MAX_WORDS];
    logic [31:0] r_rd1, r_rd2;

    logic [CW-1:0] r_cnt1, r_cnt2, n_cnt1, n_cnt2;
    logic          r_done1, r_done2, n_done1, n_done2;
    logic          wr1, wr2;

    logic [CW-1:0] r_i1, r_i2, n_i1, n_i2;
    logic [31:0]   r_w1, r_w2, n_w1, n_w2;
    logic          r_mod1, r_mod2, n_mod1, n_mod2;

    logic [RUN_W-1:0] r_run_cnt, n_run_cnt;
    logic             r_run_val, n_run_val;

    logic [wah_pkg::NOUT_W-1:0] r_nout, n_nout;
    logic        r_pend_v, n_pend_v;
    logic [31:0] r_pend, n_pend;
    logic        r_out_v, n_out_v;
    logic [31:0] r_out_word, n_out_word;
    logic        r_out_last, n_out_last;

    // Step evaluation.
    logic [31:0] e1, e2, fw, lit, lit_word, emit_word, chunk_word;
    logic [29:0] c1, c2, c, m, chunk;
    logic [30:0] num;
    logic        f1, f2, v, dom, is_or;
    logic        kind_lit, add_val, adv1, adv2, set1, set2;
    logic [29:0] add_amt;
    logic [31:0] mw1, mw2;
    logic        emit, out_free, run_nz;

    always_comb begin
        is_or    = (i_op_mode == wah_pkg::OP_OR);
        e1       = r_mod1 ? r_w1 : r_rd1;
        e2       = r_mod2 ? r_w2 : r_rd2;
        f1       = e1[31];
        f2       = e2[31];
        c1       = e1[29:0];
        c2       = e2[29:0];
        kind_lit = 1'b0;
        add_val  = 1'b0;
        add_amt  = wah_pkg::LIT_BITS;
        lit_word = '0;
        adv1     = 1'b0;
        adv2     = 1'b0;
        set1     = 1'b0;
        set2     = 1'b0;
        mw1      = e1;
        mw2      = e2;
        m        = '0;
        fw       = f1 ? e1 : e2;
        lit      = f1 ? e2 : e1;
        c        = fw[29:0];
        v        = fw[30];
        dom      = is_or ? v : !v;
        num      = is_or ? (e1[30:0] | e2[30:0]) : (e1[30:0] & e2[30:0]);
        if (f1 && f2) begin
            m       = (c1 < c2) ? c1 : c2;
            add_val = is_or ? (e1[30] | e2[30]) : (e1[30] & e2[30]);
            add_amt = m;
            if (c1 == c2) begin
                adv1 = 1'b1;
                adv2 = 1'b1;
            end else if (c1 > c2) begin
                mw1  = {e1[31:30], c1 - c2};
                set1 = 1'b1;
                adv2 = 1'b1;
            end else begin
                mw2  = {e2[31:30], c2 - c1};
                set2 = 1'b1;
                adv1 = 1'b1;
            end
        end else if (f1 || f2) begin
            if (dom) begin
                add_val = v;
            end else begin
                kind_lit = 1'b1;
                lit_word = lit;
            end
            // A fill no longer than one literal is used up whole.
            if (c <= wah_pkg::LIT_BITS) begin
                adv1 = f1;
                adv2 = !f1;
            end else if (f1) begin
                mw1  = {fw[31:30], c - wah_pkg::LIT_BITS};
                set1 = 1'b1;
            end else begin
                mw2  = {fw[31:30], c - wah_pkg::LIT_BITS};
                set2 = 1'b1;
            end
            if (f1) begin
                adv2 = 1'b1;
            end else begin
                adv1 = 1'b1;
            end
        end else begin
            adv1 = 1'b1;
            adv2 = 1'b1;
            if (num == '0) begin
                add_val = 1'b0;
            end else if (num == wah_pkg::LIT_ONES) begin
                add_val = 1'b1;
            end else begin
                kind_lit = 1'b1;
                lit_word = {1'b0, num};
            end
        end
    end

    always_comb begin
        run_nz     = (r_run_cnt != '0);
        chunk      = (r_run_cnt > RUN_W'(wah_pkg::LEN_MASK)) ? wah_pkg::LEN_MASK
                                                              : r_run_cnt[29:0];
        chunk_word = {1'b1, r_run_val, chunk};
        emit       = i_cmd.chunk || (i_cmd.apply && kind_lit);
        emit_word  = i_cmd.chunk ? chunk_word : lit_word;
        out_free   = !r_out_v || i_out_ready;
    end

    always_comb begin
        o_sts.trig       = (r_done1 || (!i_operand_select && i_last_word)) &&
                           (r_done2 || (i_operand_select && i_last_word));
        o_sts.loop_ok    = (r_i1 < r_cnt1) && (r_i2 < r_cnt2);
        o_sts.run_nz     = run_nz;
        o_sts.need_flush = run_nz && (kind_lit || (add_val != r_run_val));
        o_sts.kind_lit   = kind_lit;
        o_sts.can_push   = !r_pend_v || out_free;
        o_sts.at_limit   = (r_nout == wah_pkg::NOUT_W'(wah_pkg::MAX_OUT - 1));
        o_sts.fin_ok     = !r_pend_v || out_free;
    end

    // Loading of the operand stores.
    always_comb begin
        n_cnt1  = r_cnt1;
        n_cnt2  = r_cnt2;
        n_done1 = r_done1;
        n_done2 = r_done2;
        wr1     = 1'b0;
        wr2     = 1'b0;
        if (i_cmd.load) begin
            if (!i_operand_select && !r_done1) begin
                if (r_cnt1 < CW'(MAX_WORDS)) begin
                    wr1    = 1'b1;
                    n_cnt1 = r_cnt1 + 1'b1;
                end
                n_done1 = i_last_word;
            end
            if (i_operand_select && !r_done2) begin
                if (r_cnt2 < CW'(MAX_WORDS)) begin
                    wr2    = 1'b1;
                    n_cnt2 = r_cnt2 + 1'b1;
                end
                n_done2 = i_last_word;
            end
        end
        if (i_cmd.finish) begin
            n_cnt1  = '0;
            n_cnt2  = '0;
            n_done1 = 1'b0;
            n_done2 = 1'b0;
        end
    end

    // Walk, running fill and output staging.
    always_comb begin
        n_i1       = r_i1;
        n_i2       = r_i2;
        n_w1       = r_w1;
        n_w2       = r_w2;
        n_mod1     = r_mod1;
        n_mod2     = r_mod2;
        n_run_cnt  = r_run_cnt;
        n_run_val  = r_run_val;
        n_nout     = r_nout;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out_v    = r_out_v && !i_out_ready;
        n_out_word = r_out_word;
        n_out_last = r_out_last;
        if (i_cmd.init) begin
            n_i1      = '0;
            n_i2      = '0;
            n_mod1    = 1'b0;
            n_mod2    = 1'b0;
            n_run_cnt = '0;
            n_run_val = 1'b0;
            n_nout    = '0;
        end
        if (i_cmd.chunk) begin
            n_run_cnt = r_run_cnt - RUN_W'(chunk);
        end
        if (i_cmd.apply) begin
            if (!kind_lit) begin
                n_run_cnt = r_run_cnt + RUN_W'(add_amt);
                n_run_val = add_val;
            end
            if (adv1) begin
                n_i1   = r_i1 + 1'b1;
                n_mod1 = 1'b0;
            end else if (set1) begin
                n_w1   = mw1;
                n_mod1 = 1'b1;
            end
            if (adv2) begin
                n_i2   = r_i2 + 1'b1;
                n_mod2 = 1'b0;
            end else if (set2) begin
                n_w2   = mw2;
                n_mod2 = 1'b1;
            end
        end
        // The newest word waits in the pending stage until the next one
        // shows whether it is the final word of the result.
        if (emit) begin
            n_nout   = r_nout + 1'b1;
            n_pend   = emit_word;
            n_pend_v = 1'b1;
            if (r_pend_v) begin
                n_out_v    = 1'b1;
                n_out_word = r_pend;
                n_out_last = 1'b0;
            end
        end
        if (i_cmd.finish && r_pend_v) begin
            n_pend_v   = 1'b0;
            n_out_v    = 1'b1;
            n_out_word = r_pend;
            n_out_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr1) begin
            r_store1[r_cnt1[IW-1:0]] <= i_comp_word;
        end
        if (wr2) begin
            r_store2[r_cnt2[IW-1:0]] <= i_comp_word;
        end
        r_rd1 <= r_store1[n_i1[IW-1:0]];
        r_rd2 <= r_store2[n_i2[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt1    <= '0;
            r_cnt2    <= '0;
            r_done1   <= 1'b0;
            r_done2   <= 1'b0;
            r_i1      <= '0;
            r_i2      <= '0;
            r_mod1    <= 1'b0;
            r_mod2    <= 1'b0;
            r_run_cnt <= '0;
            r_run_val <= 1'b0;
            r_nout    <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_cnt1    <= n_cnt1;
            r_cnt2    <= n_cnt2;
            r_done1   <= n_done1;
            r_done2   <= n_done2;
            r_i1      <= n_i1;
            r_i2      <= n_i2;
            r_mod1    <= n_mod1;
            r_mod2    <= n_mod2;
            r_run_cnt <= n_run_cnt;
            r_run_val <= n_run_val;
            r_nout    <= n_nout;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1       <= n_w1;
        r_w2       <= n_w2;
        r_pend     <= n_pend;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    assign o_out_valid   = r_out_v;
    assign o_result_word = r_out_word;
    assign o_last_result = r_out_last;

    `WAH_ASSERT_NOW(a_emit_has_room, emit, o_sts.can_push)
    `WAH_ASSERT_NOW(a_apply_in_walk, i_cmd.apply, o_sts.loop_ok && !o_sts.need_flush)
    `WAH_ASSERT_NEXT(a_finish_clears, i_cmd.finish,
                     !r_pend_v && r_cnt1 == '0 && r_cnt2 == '0 && !r_done1 && !r_done2)

endmodule

[src/wah_bitmap_and_or.sv]
// ----------------------------------------------------------------------------
// WAH bitmap AND/OR merge
// Collects two WAH-compressed bitmaps and returns their compressed AND or OR.
// ----------------------------------------------------------------------------
// Each request on the input channel carries one 32-bit WAH word and the bitmap
// it belongs to; requests are taken back to back while no merge is running. Up
// to MAX_WORDS words are kept per bitmap, words beyond that are dropped, and
// words for a bitmap whose last word was already seen are ignored. The request
// that completes both bitmaps starts the merge, and the input stays stalled
// until the merge has ended: the prepare state reads the first store entries,
// then the walk performs the merge steps and flushes fill words from the
// running fill, the walk state sees that the walk is over, and the finish state
// releases the final word; the walk and the release wait while the output is
// blocked. The walk is bound by the single registered read port of each store;
// a merge of n1 and n2 stored words takes at most n1 + n2 - 1 steps. Result
// requests leave through an output register, so the block keeps working while
// a word waits to be taken; at most 64 words are returned, and the final one is
// marked with o_last_result. The logical operation comes from register op_mode
// at address 0 (0 AND, 1 OR) and may only be changed while no merge is running.
// ----------------------------------------------------------------------------
module wah_bitmap_and_or #(
    parameter int MAX_WORDS = wah_pkg::MAX_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operand_select,
    input  logic [31:0] i_comp_word,
    input  logic        i_last_word,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_word,
    output logic        o_last_result
);

    logic          r_op_mode;
    wah_pkg::t_cmd cmd;
    wah_pkg::t_sts sts;

    // The register file holds a single bit; bit 2 of the byte address picks
    // the register, so addresses 4 to 7 read as zero and ignore writes.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= wah_pkg::OP_AND;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_op_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (!paddr[2]) begin
            prdata[0] = r_op_mode;
        end
    end

    // The controller decides every step; the datapath holds the stores, the
    // walk position, the running fill and the two output stages.
    wah_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wah_dp #(
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op_mode        (r_op_mode),
        .i_operand_select (i_operand_select),
        .i_comp_word      (i_comp_word),
        .i_last_word      (i_last_word),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_word    (o_result_word),
        .o_last_result    (o_last_result)
    );

endmodule
